/* rtl/core/mtk_pkg.sv */
// ----------------------------------------------------------------------------
// mtk_pkg
// Shared types and constants for the k-of-n multiplicity trigger.
// ----------------------------------------------------------------------------
package mtk_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int COUNT_W  = 10;
    localparam int NUM_TOP  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL    = 2'd0,
        CFG_REQUIRED = 2'd1,
        CFG_CHANNELS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] level;
        logic [COUNT_W-1:0]         required;
        logic [COUNT_W-1:0]         channels;
    } t_cfg;

    // word travelling down the sorter chain
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [MAG_W-1:0] val;
        logic             fired;
        logic             shrt;
        logic             kvalid;
        logic [MAG_W-1:0] kth;
    } t_token;

endpackage

/* rtl/core/mtk_front.sv */
// ----------------------------------------------------------------------------
// mtk_front
// Channel counter cell: tracks channel index and at-or-above-level count, builds
// the per-word token and the event verdict on the last word.
// ----------------------------------------------------------------------------
module mtk_front
    import mtk_pkg::*;
#(
    parameter int MAX_CHANNELS = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    input  t_cfg                       i_cfg,
    output t_token                     o_tok
);

    localparam int CMP_W = COUNT_W + 1;

    logic [COUNT_W-1:0] r_index, n_index;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] w_eff;
    logic               w_part;
    logic               w_short;
    t_token             r_tok, n_tok;

    always_comb begin
        if ({1'b0, i_cfg.channels} > CMP_W'(MAX_CHANNELS)) begin
            w_eff = COUNT_W'(MAX_CHANNELS);
        end else begin
            w_eff = i_cfg.channels;
        end
        w_part  = r_index < w_eff;
        n_index = r_index;
        n_count = r_count;
        if (w_part) begin
            n_index = r_index + 1'b1;
            if (i_sample >= i_cfg.level && r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end
        w_short = n_index < w_eff;

        n_tok        = '0;
        n_tok.valid  = i_valid;
        n_tok.last   = i_last;
        n_tok.val    = (w_part && i_sample > 0) ? i_sample[MAG_W-1:0] : '0;
        n_tok.shrt   = i_last && w_short;
        n_tok.fired  = i_last && !w_short && i_cfg.required != '0
                       && n_count >= i_cfg.required;
        n_tok.kvalid = i_last && !w_short
                       && (i_cfg.required == COUNT_W'(1) || i_cfg.required == COUNT_W'(2)
                           || i_cfg.required == COUNT_W'(3));
        if (i_last) begin
            n_index = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_count <= '0;
        end else if (i_en && i_valid) begin
            r_index <= n_index;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok.valid <= n_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok.last   <= n_tok.last;
            r_tok.val    <= n_tok.val;
            r_tok.fired  <= n_tok.fired;
            r_tok.shrt   <= n_tok.shrt;
            r_tok.kvalid <= n_tok.kvalid;
            r_tok.kth    <= n_tok.kth;
        end
    end

    assign o_tok = r_tok;

endmodule

/* rtl/core/mtk_cell.sv */
// ----------------------------------------------------------------------------
// mtk_cell
// One sorter cell: holds one of the top values, keeps the larger of its
// value and the incoming one and hands the smaller to the next cell.
// ----------------------------------------------------------------------------
module mtk_cell
    import mtk_pkg::*;
#(
    parameter int RANK = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [COUNT_W-1:0] i_required,
    input  t_token             i_tok,
    output t_token             o_tok
);

    logic [MAG_W-1:0] r_val, n_val;
    logic [MAG_W-1:0] w_keep;
    logic             w_bigger;
    t_token           r_tok, n_tok;

    always_comb begin
        w_bigger = i_tok.val > r_val;
        w_keep   = w_bigger ? i_tok.val : r_val;
        n_val    = r_val;
        n_tok    = i_tok;
        if (i_tok.valid) begin
            n_tok.val = w_bigger ? r_val : i_tok.val;
            n_val     = w_keep;
            if (i_tok.last) begin
                n_val = '0;
                if (i_tok.kvalid && i_required == COUNT_W'(RANK)) begin
                    n_tok.kth = w_keep;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val       <= '0;
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_val       <= n_val;
            r_tok.valid <= n_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok.last   <= n_tok.last;
            r_tok.val    <= n_tok.val;
            r_tok.fired  <= n_tok.fired;
            r_tok.shrt   <= n_tok.shrt;
            r_tok.kvalid <= n_tok.kvalid;
            r_tok.kth    <= n_tok.kth;
        end
    end

    assign o_tok = r_tok;

endmodule

/* rtl/core/multiplicity_trigger_kth_max_top.sv */
// ----------------------------------------------------------------------------
// multiplicity_trigger_kth_max_top
// k-of-n multiplicity trigger with k-th largest sample report.
//
// Input stream: one word per channel sample (signed 16-bit, 4 fraction
// bits), tlast on the final sample of the event. Only the first
// min(channels_used, MAX_CHANNELS) samples of an event take part.
// Output stream: one word per event, carrying fired, the k-th largest
// sample (floor 0), its valid flag and the short-event flag.
// Throughput: one sample per cycle while the output is not stalled; the
// sorter chain of three cells moves one step each enabled cycle, so
// events may follow back to back. After the last sample is accepted,
// the result passes from the counter cell, which loads on the accepting
// edge, through three sorter cells and the output register.
// Stall: the whole chain holds while the output word waits; s_tready
// is low only then.
// Reset: level 0, required count 3, channels used 512, all event state
// and the pipeline cleared. Config writes must be made only while idle.
// ----------------------------------------------------------------------------
module multiplicity_trigger_kth_max_top
    import mtk_pkg::*;
#(
    parameter int MAX_CHANNELS = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [15:0]          i_s_tdata,   // [15:0] sample
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [23:0]          o_m_tdata,   // [0] fired, [15:1] kth_largest,
                                              // [16] kth_valid, [17] short_event
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    t_cfg             r_cfg;
    t_token           w_tok [0:NUM_TOP];
    logic             w_en;
    logic             r_out_valid;
    logic             r_fired, r_kvalid, r_shrt;
    logic [MAG_W-1:0] r_kth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level    <= '0;
            r_cfg.required <= COUNT_W'(3);
            r_cfg.channels <= COUNT_W'(512);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEVEL:    r_cfg.level    <= i_cfg_data;
                CFG_REQUIRED: r_cfg.required <= i_cfg_data[COUNT_W-1:0];
                CFG_CHANNELS: r_cfg.channels <= i_cfg_data[COUNT_W-1:0];
                default:      ;
            endcase
        end
    end

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    mtk_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_sample(i_s_tdata),
        .i_last  (i_s_tlast),
        .i_cfg   (r_cfg),
        .o_tok   (w_tok[0])
    );

    for (genvar g = 0; g < NUM_TOP; g++) begin : g_cell
        mtk_cell #(
            .RANK(g + 1)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_required(r_cfg.required),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tok[NUM_TOP].valid && w_tok[NUM_TOP].last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fired  <= w_tok[NUM_TOP].fired;
            r_kth    <= w_tok[NUM_TOP].kth;
            r_kvalid <= w_tok[NUM_TOP].kvalid;
            r_shrt   <= w_tok[NUM_TOP].shrt;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_shrt, r_kvalid, r_kth, r_fired};

endmodule
